// ===== rtl/bvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-vector set engine package
// Command codes, field widths and parameter defaults shared by the engine.
// ----------------------------------------------------------------------------
package bvs_pkg;

  // Parameter defaults
  localparam int NUM_SETS_DEF     = 4;
  localparam int MAX_UNIVERSE_DEF = 1024;
  localparam int WORD_BITS_DEF    = 32;

  // Fixed port field widths
  localparam int CMD_W   = 3;
  localparam int SEL_W   = 2;
  localparam int ITEM_W  = 10;
  localparam int UNIV_W  = 11;
  localparam int COUNT_W = 11;

  localparam logic [UNIV_W-1:0]  UNIVERSE_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 11'h7FF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_LOOKUP    = 3'd2,
    CMD_COUNT     = 3'd3,
    CMD_UNION     = 3'd4,
    CMD_INTERSECT = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOCATE = 7'b0000100,
    ST_BIT    = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

endpackage

// ===== rtl/bvs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/bit_vector_set_engine_top.sv =====
// ----------------------------------------------------------------------------
// Bit-vector set engine
// A bank of bit-vector sets kept in one RAM of WORD_BITS-bit words, with
// add, remove, lookup, count, union, intersect and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ channel (valid/stall) and each produces exactly
//   one result transfer on the out_ channel (valid/stall). The universe size
//   is written through the cfg_ channel (valid/ready, always ready) and should
//   only be changed while no command is in flight.
//   One command is processed at a time; in_stall is high while it runs. The
//   next command is taken at the earliest in the cycle after a result is registered.
//   How each command is processed, with W = WORD_BITS:
//     add, remove, lookup:       the word is located by stepping a bit base
//                                 one word per cycle, then one RAM read and,
//                                 for add and remove, one write
//     count, union, intersect:   one word per cycle through the dual-read RAM
//                                 port and the shared popcount or OR/AND unit
//     clear:                     every word of the target set is zeroed
//     out-of-universe item, nop: no RAM access, straight to the result
//   After reset a clearing pass zeroes all NUM_SETS * ceil(MAX_UNIVERSE/W)
//   RAM words (128 by default), one word per cycle, with in_stall high.
//   Results sit in an output register; while the receiver stalls, the next
//   command is still taken and runs up to its result, then waits.
// ----------------------------------------------------------------------------
module bit_vector_set_engine_top #(
  parameter int NUM_SETS     = bvs_pkg::NUM_SETS_DEF,
  parameter int MAX_UNIVERSE = bvs_pkg::MAX_UNIVERSE_DEF,
  parameter int WORD_BITS    = bvs_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bvs_pkg::CMD_W-1:0]   in_cmd,
  input  logic [bvs_pkg::SEL_W-1:0]   in_target_set,
  input  logic [bvs_pkg::SEL_W-1:0]   in_first_source,
  input  logic [bvs_pkg::SEL_W-1:0]   in_second_source,
  input  logic [bvs_pkg::ITEM_W-1:0]  in_item_number,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_member,
  output logic [bvs_pkg::COUNT_W-1:0] out_member_count,
  output logic                        out_status,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bvs_pkg::UNIV_W-1:0]  cfg_universe_size
);

  localparam int WPS   = (MAX_UNIVERSE + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = NUM_SETS * WPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WIW   = $clog2(WPS + 1);
  localparam int WIX   = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int BW    = $clog2(MAX_UNIVERSE + 2 * WORD_BITS + 1);
  localparam int CW    = (BW > bvs_pkg::UNIV_W) ? BW : bvs_pkg::UNIV_W;
  localparam int OFW   = $clog2(WORD_BITS);
  localparam int PCW   = $clog2(WORD_BITS + 1);
  localparam int SUMW  = bvs_pkg::COUNT_W + 1;

  localparam logic [CW-1:0] MAX_U = CW'(MAX_UNIVERSE);
  localparam logic [CW-1:0] WB_C  = CW'(WORD_BITS);

  // Control registers
  bvs_pkg::state_t            state_r, state_nxt;
  logic [AW-1:0]              init_addr_r, init_addr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bvs_pkg::UNIV_W-1:0] universe_r, universe_nxt;
  logic                       pend_r, pend_nxt;

  // Command and datapath registers
  bvs_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [SW-1:0]               tgt_r, tgt_nxt;
  logic [SW-1:0]               src1_r, src1_nxt;
  logic [SW-1:0]               src2_r, src2_nxt;
  logic [bvs_pkg::ITEM_W-1:0]  item_r, item_nxt;
  logic [WIW-1:0]              word_r, word_nxt;
  logic [WIX-1:0]              pword_r, pword_nxt;
  logic [CW-1:0]               base_r, base_nxt;
  logic [bvs_pkg::COUNT_W-1:0] acc_r, acc_nxt;
  logic                        member_r, member_nxt;
  logic                        status_r, status_nxt;
  logic                        out_is_member_r, out_is_member_nxt;
  logic [bvs_pkg::COUNT_W-1:0] out_member_count_r, out_member_count_nxt;
  logic                        out_status_r, out_status_nxt;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr_a;
  logic [AW-1:0]        ram_raddr_b;
  logic [WORD_BITS-1:0] ram_rdata_a;
  logic [WORD_BITS-1:0] ram_rdata_b;

  // Shared datapath
  logic [CW-1:0]        uni_ext;
  logic [CW-1:0]        act_univ;
  logic [CW-1:0]        item_ext;
  logic [CW-1:0]        bit_diff;
  logic [OFW-1:0]       bit_off;
  logic [WORD_BITS-1:0] bit_mask;
  logic [PCW-1:0]       popcnt;
  logic [SUMW-1:0]      acc_sum;
  logic                 in_accept;
  logic                 issue;
  bvs_pkg::cmd_t        in_cmd_e;

  function automatic logic [SW-1:0] pick_set(input logic [bvs_pkg::SEL_W-1:0] sel);
    int v;
    v = int'(sel);
    for (int k = 0; k < 3; k++) begin
      if (v >= NUM_SETS) begin
        v = v - NUM_SETS;
      end
    end
    return SW'(v);
  endfunction

  function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] s,
                                              input logic [WIX-1:0] w);
    return AW'(s) * AW'(WPS) + AW'(w);
  endfunction

  bvs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign in_stall         = (state_r != bvs_pkg::ST_IDLE);
  assign in_accept        = in_valid && !in_stall;
  assign in_cmd_e         = bvs_pkg::cmd_t'(in_cmd);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_is_member    = out_is_member_r;
  assign out_member_count = out_member_count_r;
  assign out_status       = out_status_r;

  // A register value above the largest universe saturates.
  assign uni_ext  = CW'(universe_r);
  assign act_univ = (uni_ext > MAX_U) ? MAX_U : uni_ext;
  assign item_ext = CW'(item_r);
  assign bit_diff = item_ext - base_r;
  assign bit_off  = bit_diff[OFW-1:0];
  assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_off;
  assign issue    = (base_r < act_univ);

  always_comb begin
    popcnt = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      popcnt = popcnt + PCW'(ram_rdata_a[i]);
    end
  end

  assign acc_sum = SUMW'(acc_r) + SUMW'(popcnt);

  always_comb begin
    state_nxt            = state_r;
    init_addr_nxt        = init_addr_r;
    out_valid_nxt        = out_valid_r;
    universe_nxt         = universe_r;
    pend_nxt             = pend_r;
    cmd_nxt              = cmd_r;
    tgt_nxt              = tgt_r;
    src1_nxt             = src1_r;
    src2_nxt             = src2_r;
    item_nxt             = item_r;
    word_nxt             = word_r;
    pword_nxt            = pword_r;
    base_nxt             = base_r;
    acc_nxt              = acc_r;
    member_nxt           = member_r;
    status_nxt           = status_r;
    out_is_member_nxt    = out_is_member_r;
    out_member_count_nxt = out_member_count_r;
    out_status_nxt       = out_status_r;
    ram_we               = 1'b0;
    ram_waddr            = '0;
    ram_wdata            = '0;
    ram_raddr_a          = '0;
    ram_raddr_b          = '0;

    if (cfg_valid) begin
      universe_nxt = cfg_universe_size;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bvs_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_addr_r;
        if (init_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = bvs_pkg::ST_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + 1'b1;
        end
      end

      bvs_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_cmd_e;
          tgt_nxt    = pick_set(in_target_set);
          src1_nxt   = pick_set(in_first_source);
          src2_nxt   = pick_set(in_second_source);
          item_nxt   = in_item_number;
          word_nxt   = '0;
          base_nxt   = '0;
          acc_nxt    = '0;
          member_nxt = 1'b0;
          status_nxt = 1'b0;
          pend_nxt   = 1'b0;
          unique case (in_cmd_e)
            bvs_pkg::CMD_ADD, bvs_pkg::CMD_REMOVE, bvs_pkg::CMD_LOOKUP: begin
              if (CW'(in_item_number) >= act_univ) begin
                status_nxt = 1'b1;
                state_nxt  = bvs_pkg::ST_RESP;
              end else begin
                state_nxt = bvs_pkg::ST_LOCATE;
              end
            end
            bvs_pkg::CMD_COUNT, bvs_pkg::CMD_UNION, bvs_pkg::CMD_INTERSECT: begin
              state_nxt = bvs_pkg::ST_WALK;
            end
            bvs_pkg::CMD_CLEAR: begin
              state_nxt = bvs_pkg::ST_CLEAR;
            end
            bvs_pkg::CMD_NOP: begin
              state_nxt = bvs_pkg::ST_RESP;
            end
            default: begin
              state_nxt = bvs_pkg::ST_RESP;
            end
          endcase
        end
      end

      // Step the bit base one word at a time until the item falls inside it.
      bvs_pkg::ST_LOCATE: begin
        if (item_ext >= base_r + WB_C) begin
          base_nxt = base_r + WB_C;
          word_nxt = word_r + 1'b1;
        end else begin
          ram_raddr_a = word_addr(tgt_r, word_r[WIX-1:0]);
          state_nxt   = bvs_pkg::ST_BIT;
        end
      end

      bvs_pkg::ST_BIT: begin
        ram_waddr = word_addr(tgt_r, word_r[WIX-1:0]);
        priority if (cmd_r == bvs_pkg::CMD_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata_a | bit_mask;
        end else if (cmd_r == bvs_pkg::CMD_REMOVE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata_a & ~bit_mask;
        end else begin
          member_nxt = |(ram_rdata_a & bit_mask);
        end
        state_nxt = bvs_pkg::ST_RESP;
      end

      // Reads for word k are issued while the data of word k-1 is consumed.
      bvs_pkg::ST_WALK: begin
        ram_raddr_a = word_addr((cmd_r == bvs_pkg::CMD_COUNT) ? tgt_r : src1_r,
                                word_r[WIX-1:0]);
        ram_raddr_b = word_addr(src2_r, word_r[WIX-1:0]);
        if (pend_r) begin
          if (cmd_r == bvs_pkg::CMD_COUNT) begin
            acc_nxt = (acc_sum > SUMW'(bvs_pkg::COUNT_MAX)) ?
                      bvs_pkg::COUNT_MAX : acc_sum[bvs_pkg::COUNT_W-1:0];
          end else begin
            ram_we    = 1'b1;
            ram_waddr = word_addr(tgt_r, pword_r);
            ram_wdata = (cmd_r == bvs_pkg::CMD_UNION) ? (ram_rdata_a | ram_rdata_b)
                                                      : (ram_rdata_a & ram_rdata_b);
          end
        end
        pend_nxt  = issue;
        pword_nxt = word_r[WIX-1:0];
        if (issue) begin
          base_nxt = base_r + WB_C;
          word_nxt = word_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = bvs_pkg::ST_RESP;
        end
      end

      bvs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(tgt_r, word_r[WIX-1:0]);
        if (word_r == WIW'(WPS - 1)) begin
          state_nxt = bvs_pkg::ST_RESP;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end

      bvs_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_is_member_nxt    = member_r;
          out_member_count_nxt = acc_r;
          out_status_nxt       = status_r;
          state_nxt            = bvs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bvs_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bvs_pkg::ST_INIT;
      init_addr_r <= '0;
      out_valid_r <= 1'b0;
      universe_r  <= bvs_pkg::UNIVERSE_RESET;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      out_valid_r <= out_valid_nxt;
      universe_r  <= universe_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r              <= cmd_nxt;
    tgt_r              <= tgt_nxt;
    src1_r             <= src1_nxt;
    src2_r             <= src2_nxt;
    item_r             <= item_nxt;
    word_r             <= word_nxt;
    pword_r            <= pword_nxt;
    base_r             <= base_nxt;
    acc_r              <= acc_nxt;
    member_r           <= member_nxt;
    status_r           <= status_nxt;
    out_is_member_r    <= out_is_member_nxt;
    out_member_count_r <= out_member_count_nxt;
    out_status_r       <= out_status_nxt;
  end

endmodule
